// ===== rtl/core/sgc_pkg.sv =====
// shared types and codes of the scatter-gather cursor core
package sgc_pkg;

    // request type codes on req_type
    localparam logic [2:0] REQ_LOAD    = 3'd0;
    localparam logic [2:0] REQ_GATHER  = 3'd1;
    localparam logic [2:0] REQ_SCATTER = 3'd2;
    localparam logic [2:0] REQ_SEEK    = 3'd3;
    localparam logic [2:0] REQ_REWIND  = 3'd4;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ERR      = 2'd1;
    localparam logic [1:0] STATUS_BAD_SLOT = 2'd2;

    // configuration register indexes
    localparam logic CFG_DESC_COUNT  = 1'b0;
    localparam logic CFG_MEMORY_KIND = 1'b1;

    // most copy commands one request may produce
    localparam int MAX_RESULTS = 16;

    // request queue between front and back, power of two deep
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    // one descriptor word in the table: base over length
    localparam int DESC_W = 96;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_LOAD_BAD,
        OP_GATHER,
        OP_SCATTER,
        OP_SEEK,
        OP_REWIND,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  slot;
        logic [63:0] base;
        logic [31:0] size;
        logic [31:0] length;
        logic [31:0] seek;
    } req_t;

    typedef struct packed {
        logic [4:0]  desc_index;
        logic [63:0] buf_addr;
        logic [31:0] stream_offset;
        logic [31:0] copy_len;
        logic        direction;
        logic [2:0]  mem_tag;
        logic        last;
        logic [31:0] total_moved;
        logic [4:0]  cursor_index_out;
        logic [31:0] cursor_offset_out;
        logic [1:0]  status;
    } result_t;

endpackage

// ===== rtl/core/sgc_ram.sv =====
// generic single write port ram with registered read
module sgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/sgc_front.sv =====
// request front end: classifies requests and queues them for the walker
module sgc_front #(
    parameter int MAX_DESC = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [2:0]    req_type,
    input  logic [3:0]    desc_slot,
    input  logic [63:0]   desc_base,
    input  logic [31:0]   desc_size,
    input  logic [31:0]   xfer_length,
    input  logic [31:0]   seek_distance,
    output logic          q_valid,
    output sgc_pkg::req_t q_head,
    input  logic          q_pop
);
    import sgc_pkg::*;

    localparam int QCW = $clog2(Q_DEPTH + 1);

    req_t            entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [QCW-1:0]  count_reg;
    op_t             op;
    req_t            req_in;
    logic            push;

    always_comb
    begin
        unique case (req_type)
            REQ_LOAD:    op = (int'(desc_slot) < MAX_DESC) ? OP_LOAD : OP_LOAD_BAD;
            REQ_GATHER:  op = OP_GATHER;
            REQ_SCATTER: op = OP_SCATTER;
            REQ_SEEK:    op = OP_SEEK;
            REQ_REWIND:  op = OP_REWIND;
            default:     op = OP_BAD;
        endcase
    end

    always_comb
    begin
        req_in.op     = op;
        req_in.slot   = desc_slot;
        req_in.base   = desc_base;
        req_in.size   = desc_size;
        req_in.length = xfer_length;
        req_in.seek   = seek_distance;
    end

    assign busy    = (count_reg == QCW'(Q_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (q_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= req_in;
        end
    end

endmodule

// ===== rtl/core/sgc_back.sv =====
// walker back end: runs queued requests against the table and the cursor
module sgc_back #(
    parameter int MAX_DESC = 16,
    localparam int IW = $clog2(MAX_DESC + 1),
    localparam int AW = (MAX_DESC > 1) ? $clog2(MAX_DESC) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  sgc_pkg::req_t         q_head,
    output logic                  q_pop,
    input  logic [IW-1:0]         desc_count_eff,
    input  logic [2:0]            mem_kind,
    output logic                  ram_we,
    output logic [AW-1:0]         ram_waddr,
    output logic [sgc_pkg::DESC_W-1:0] ram_wdata,
    output logic [AW-1:0]         ram_raddr,
    input  logic [sgc_pkg::DESC_W-1:0] ram_rdata,
    output logic                  res_valid,
    output sgc_pkg::result_t      res
);
    import sgc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_PLAN,
        ST_EMIT,
        ST_SEEK_FWD,
        ST_SEEK_BACK
    } state_t;

    state_t         state_reg;
    req_t           req_reg;
    logic [IW-1:0]  cur_idx_reg;
    logic [31:0]    cur_off_reg;
    logic [IW-1:0]  idx_reg;
    logic [31:0]    off_reg;
    logic [31:0]    it_reg;
    logic [31:0]    want_reg;
    logic [4:0]     k_reg;
    logic [4:0]     plan_k_reg;
    logic [IW-1:0]  fin_idx_reg;
    logic [31:0]    fin_off_reg;
    logic [33:0]    pos_reg;
    logic           res_valid_reg;
    result_t        res_reg;

    logic [31:0]    len_w;
    logic [63:0]    base_w;
    logic [31:0]    rem;
    logic [31:0]    cp;
    logic           adv;
    logic [31:0]    it_sum;
    logic           stop;
    logic           plan_done;
    logic           emit_last;
    logic           dir;
    logic [33:0]    pos_init;
    logic [IW-1:0]  rd_idx;

    function automatic result_t single_res(input logic [4:0] di, input logic [4:0] ci,
                                           input logic [31:0] co, input logic [1:0] st,
                                           input logic [2:0] tag);
        result_t r;
        r                   = '0;
        r.desc_index        = di;
        r.mem_tag           = tag;
        r.last              = 1'b1;
        r.cursor_index_out  = ci;
        r.cursor_offset_out = co;
        r.status            = st;
        return r;
    endfunction

    assign len_w  = ram_rdata[31:0];
    assign base_w = ram_rdata[DESC_W-1:32];
    assign dir    = (req_reg.op == OP_SCATTER);

    // one descriptor step of the walk, data for idx_reg is on the read port
    always_comb
    begin
        rem       = (len_w > off_reg) ? (len_w - off_reg) : 32'd0;
        cp        = (rem < want_reg) ? rem : want_reg;
        adv       = (cp < want_reg);
        it_sum    = it_reg + cp;
        stop      = (idx_reg >= desc_count_eff) || (k_reg >= 5'(MAX_RESULTS));
        plan_done = (want_reg == 32'd0) || (stop && dir);
        emit_last = ((k_reg + 5'd1) == plan_k_reg);
        pos_init  = {2'b00, cur_off_reg} + {{2{req_reg.seek[31]}}, req_reg.seek};
    end

    // read address runs one step ahead of the walk
    always_comb
    begin
        unique case (state_reg)
            ST_START:
                rd_idx = (req_reg.op == OP_SEEK && pos_init[33]) ? cur_idx_reg - 1'b1
                                                                : cur_idx_reg;
            ST_PLAN:
                rd_idx = (!plan_done && !stop) ? idx_reg + 1'b1 : cur_idx_reg;
            ST_EMIT, ST_SEEK_FWD:
                rd_idx = idx_reg + 1'b1;
            ST_SEEK_BACK:
                rd_idx = idx_reg - IW'(2);
            default:
                rd_idx = cur_idx_reg;
        endcase
    end

    assign ram_raddr = AW'(rd_idx);
    assign ram_we    = (state_reg == ST_START) && (req_reg.op == OP_LOAD);
    assign ram_waddr = AW'(req_reg.slot);
    assign ram_wdata = {req_reg.base, req_reg.size};
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            req_reg       <= '0;
            cur_idx_reg   <= '0;
            cur_off_reg   <= '0;
            idx_reg       <= '0;
            off_reg       <= '0;
            it_reg        <= '0;
            want_reg      <= '0;
            k_reg         <= '0;
            plan_k_reg    <= '0;
            fin_idx_reg   <= '0;
            fin_off_reg   <= '0;
            pos_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        req_reg   <= q_head;
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_IDLE;
                    unique case (req_reg.op)
                        OP_LOAD, OP_LOAD_BAD:
                        begin
                            res_valid_reg <= 1'b1;
                            res_reg <= single_res(5'(req_reg.slot), 5'(cur_idx_reg),
                                                  cur_off_reg,
                                                  (req_reg.op == OP_LOAD) ? STATUS_OK
                                                                          : STATUS_BAD_SLOT,
                                                  mem_kind);
                        end
                        OP_REWIND:
                        begin
                            cur_idx_reg   <= '0;
                            cur_off_reg   <= '0;
                            res_valid_reg <= 1'b1;
                            res_reg <= single_res(5'd0, 5'd0, 32'd0, STATUS_OK, mem_kind);
                        end
                        OP_GATHER, OP_SCATTER:
                        begin
                            idx_reg   <= cur_idx_reg;
                            off_reg   <= cur_off_reg;
                            it_reg    <= '0;
                            want_reg  <= req_reg.length;
                            k_reg     <= '0;
                            state_reg <= ST_PLAN;
                        end
                        OP_SEEK:
                        begin
                            idx_reg   <= cur_idx_reg;
                            pos_reg   <= pos_init;
                            state_reg <= pos_init[33] ? ST_SEEK_BACK : ST_SEEK_FWD;
                        end
                        default:
                        begin
                            res_valid_reg <= 1'b1;
                            res_reg <= single_res(5'(cur_idx_reg), 5'(cur_idx_reg),
                                                  cur_off_reg, STATUS_ERR, mem_kind);
                        end
                    endcase
                end
                ST_PLAN:
                begin
                    // first pass only counts commands and finds the final cursor
                    if (plan_done)
                    begin
                        if (k_reg == 5'd0)
                        begin
                            cur_idx_reg   <= idx_reg;
                            cur_off_reg   <= off_reg;
                            res_valid_reg <= 1'b1;
                            res_reg <= single_res(5'(idx_reg), 5'(idx_reg), off_reg,
                                                  STATUS_OK, mem_kind);
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            fin_idx_reg <= idx_reg;
                            fin_off_reg <= off_reg;
                            plan_k_reg  <= k_reg;
                            idx_reg     <= cur_idx_reg;
                            off_reg     <= cur_off_reg;
                            it_reg      <= '0;
                            want_reg    <= req_reg.length;
                            k_reg       <= '0;
                            state_reg   <= ST_EMIT;
                        end
                    end
                    else if (stop)
                    begin
                        // gather overrun leaves the cursor alone
                        res_valid_reg <= 1'b1;
                        res_reg <= single_res(5'(cur_idx_reg), 5'(cur_idx_reg),
                                              cur_off_reg, STATUS_ERR, mem_kind);
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        it_reg   <= it_sum;
                        want_reg <= want_reg - cp;
                        k_reg    <= k_reg + 5'd1;
                        idx_reg  <= adv ? idx_reg + 1'b1 : idx_reg;
                        off_reg  <= adv ? 32'd0 : off_reg + cp;
                    end
                end
                ST_EMIT:
                begin
                    res_valid_reg             <= 1'b1;
                    res_reg.desc_index        <= 5'(idx_reg);
                    res_reg.buf_addr          <= base_w + {32'd0, off_reg};
                    res_reg.stream_offset     <= it_reg;
                    res_reg.copy_len          <= cp;
                    res_reg.direction         <= dir;
                    res_reg.mem_tag           <= mem_kind;
                    res_reg.last              <= emit_last;
                    res_reg.total_moved       <= it_sum;
                    res_reg.cursor_index_out  <= 5'(fin_idx_reg);
                    res_reg.cursor_offset_out <= fin_off_reg;
                    res_reg.status            <= STATUS_OK;
                    it_reg   <= it_sum;
                    want_reg <= want_reg - cp;
                    k_reg    <= k_reg + 5'd1;
                    idx_reg  <= adv ? idx_reg + 1'b1 : idx_reg;
                    off_reg  <= adv ? 32'd0 : off_reg + cp;
                    if (emit_last)
                    begin
                        cur_idx_reg <= fin_idx_reg;
                        cur_off_reg <= fin_off_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_SEEK_FWD:
                begin
                    if (idx_reg >= desc_count_eff)
                    begin
                        res_valid_reg <= 1'b1;
                        res_reg <= single_res(5'(cur_idx_reg), 5'(cur_idx_reg),
                                              cur_off_reg, STATUS_ERR, mem_kind);
                        state_reg     <= ST_IDLE;
                    end
                    else if (pos_reg[32:0] < {1'b0, len_w})
                    begin
                        cur_idx_reg   <= idx_reg;
                        cur_off_reg   <= pos_reg[31:0];
                        res_valid_reg <= 1'b1;
                        res_reg <= single_res(5'(idx_reg), 5'(idx_reg), pos_reg[31:0],
                                              STATUS_OK, mem_kind);
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        pos_reg <= pos_reg - {2'b00, len_w};
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_SEEK_BACK:
                begin
                    // read port holds the descriptor just below idx_reg
                    if (!pos_reg[33])
                    begin
                        cur_idx_reg   <= idx_reg;
                        cur_off_reg   <= pos_reg[31:0];
                        res_valid_reg <= 1'b1;
                        res_reg <= single_res(5'(idx_reg), 5'(idx_reg), pos_reg[31:0],
                                              STATUS_OK, mem_kind);
                        state_reg     <= ST_IDLE;
                    end
                    else if ((idx_reg == '0) || (idx_reg > desc_count_eff))
                    begin
                        res_valid_reg <= 1'b1;
                        res_reg <= single_res(5'(cur_idx_reg), 5'(cur_idx_reg),
                                              cur_off_reg, STATUS_ERR, mem_kind);
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + {2'b00, len_w};
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/scatter_gather_cursor_core.sv =====
// top level of the scatter-gather cursor core
// a request is taken at a clock edge with start high and busy low; busy rises
// only when the two-entry request queue is full. requests are load descriptor,
// gather, scatter, seek and rewind, and run strictly in order.
// results leave on result_valid for exactly one cycle each; the receiver
// cannot hold them off, and every result of a request carries the cursor as
// it stands after the whole request. last marks the final result.
// load, rewind and unknown types are queued, taken from the queue in the idle
// state and answered in the start state with a single result.
// gather and scatter walk the table twice, one descriptor a cycle through the
// registered table read port: a first pass counts commands and finds the end
// cursor, a second pass sends them. seek crosses descriptor boundaries one at a
// time, forward or backward. configuration goes through cfg_write, cfg_index
// and cfg_data; the user must write it only while idle, which the block itself
// does not enforce. index 0 sets the descriptor count, index 1 the memory tag.
// reset zeroes the cursor and both registers; table entries stay undefined
// until loaded and there is no clearing pass.
module scatter_gather_cursor_core #(
    parameter int MAX_DESC = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         req_type,
    input  logic [3:0]         desc_slot,
    input  logic [63:0]        desc_base,
    input  logic [31:0]        desc_size,
    input  logic [31:0]        xfer_length,
    input  logic signed [31:0] seek_distance,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data,
    output logic               result_valid,
    output logic [4:0]         desc_index,
    output logic [63:0]        buf_addr,
    output logic [31:0]        stream_offset,
    output logic [31:0]        copy_len,
    output logic               direction,
    output logic [2:0]         mem_tag,
    output logic               last,
    output logic [31:0]        total_moved,
    output logic [4:0]         cursor_index_out,
    output logic [31:0]        cursor_offset_out,
    output logic [1:0]         status
);
    import sgc_pkg::*;

    localparam int IW = $clog2(MAX_DESC + 1);
    localparam int AW = (MAX_DESC > 1) ? $clog2(MAX_DESC) : 1;
    localparam int CW = (IW > 5) ? IW : 5;

    logic [4:0]        desc_count_reg;
    logic [2:0]        memory_kind_reg;
    logic [CW-1:0]     count_ext;
    logic [IW-1:0]     count_eff;
    logic              q_valid;
    req_t              q_head;
    logic              q_pop;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DESC_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DESC_W-1:0] ram_rdata;
    result_t           res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_count_reg  <= '0;
            memory_kind_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DESC_COUNT:  desc_count_reg  <= cfg_data;
                CFG_MEMORY_KIND: memory_kind_reg <= cfg_data[2:0];
                default:         desc_count_reg  <= desc_count_reg;
            endcase
        end
    end

    // count is capped at the table depth
    assign count_ext = CW'(desc_count_reg);
    assign count_eff = (count_ext < CW'(MAX_DESC)) ? IW'(count_ext) : IW'(MAX_DESC);

    sgc_front #(
        .MAX_DESC (MAX_DESC)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .desc_slot     (desc_slot),
        .desc_base     (desc_base),
        .desc_size     (desc_size),
        .xfer_length   (xfer_length),
        .seek_distance (seek_distance),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop)
    );

    sgc_ram #(
        .WIDTH (DESC_W),
        .DEPTH (MAX_DESC)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sgc_back #(
        .MAX_DESC (MAX_DESC)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .desc_count_eff (count_eff),
        .mem_kind       (memory_kind_reg),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .res_valid      (result_valid),
        .res            (res)
    );

    assign desc_index        = res.desc_index;
    assign buf_addr          = res.buf_addr;
    assign stream_offset     = res.stream_offset;
    assign copy_len          = res.copy_len;
    assign direction         = res.direction;
    assign mem_tag           = res.mem_tag;
    assign last              = res.last;
    assign total_moved       = res.total_moved;
    assign cursor_index_out  = res.cursor_index_out;
    assign cursor_offset_out = res.cursor_offset_out;
    assign status            = res.status;

endmodule
